### rtl/kmp_pkg.sv
// ============================================================================
// kmp_pkg
// Shared types and constants for the streaming KMP matcher.
// ============================================================================
package kmp_pkg;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int START_W  = 10;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TEXT   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_EOL    = 2'd3;

    typedef struct packed {
        logic accept;
        logic step;
        logic extend;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic walk;
        logic byte_eq;
        logic k_zero;
    } t_status;

endpackage

### rtl/kmp_stream_matcher.sv
// ============================================================================
// kmp_stream_matcher
// Streaming Knuth-Morris-Pratt matcher with online failure-table build.
// ============================================================================
// Each input word is processed alone and yields exactly one result word.
// Clear, end-of-line, the first byte of a pattern, a dropped (overflowing)
// append and a text byte with an empty pattern skip the walk and go from
// accept straight to the result state. Any other pattern append or text
// byte walks the failure chain one link per cycle against the pattern and
// failure RAMs, with one step per fallback on that byte (fewer fallbacks
// than the pattern length; about one on average over a stream).
// The output register lets the next word be accepted while a result is
// still waiting to be taken.
module kmp_stream_matcher #(
    parameter int PATTERN_MAX = 32,
    parameter int LINE_MAX    = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [kmp_pkg::ACTION_W-1:0]    i_action,
    input  logic [kmp_pkg::BYTE_W-1:0]      i_data_byte,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_match_here,
    output logic [kmp_pkg::START_W-1:0]     o_match_start,
    output logic                            o_line_found,
    output logic                            o_pattern_overflow
);
    import kmp_pkg::*;

    t_cmd    cmd;
    t_status status;

    kmp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    kmp_dp #(
        .PATTERN_MAX (PATTERN_MAX),
        .LINE_MAX    (LINE_MAX)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_action           (i_action),
        .i_data_byte        (i_data_byte),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_match_here       (o_match_here),
        .o_match_start      (o_match_start),
        .o_line_found       (o_line_found),
        .o_pattern_overflow (o_pattern_overflow)
    );

endmodule

### rtl/kmp_ram.sv
// ============================================================================
// kmp_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/kmp_ctrl.sv
// ============================================================================
// kmp_ctrl
// Sequencer: accepts a word, runs the failure-chain walk, posts the result.
// ============================================================================
module kmp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  kmp_pkg::t_status  i_status,
    output kmp_pkg::t_cmd     o_cmd
);
    import kmp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_valid;
        o_cmd.step   = (r_state == S_CMP) && !i_status.byte_eq && !i_status.k_zero;
        o_cmd.extend = (r_state == S_CMP) && (i_status.byte_eq || i_status.k_zero);
        o_cmd.finish = (r_state == S_FIN) && out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_status.walk ? S_CMP : S_FIN;
                end
            end
            S_CMP: begin
                if (o_cmd.extend) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_ready))
        else $error("result posted over an untaken word");

    a_walk_enters_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_status.walk) |=> (r_state == S_CMP))
        else $error("walk item did not start the chain walk");

    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (o_valid && r_state == S_IDLE))
        else $error("finished item not presented");
`endif

endmodule

### rtl/kmp_dp.sv
// ============================================================================
// kmp_dp
// Datapath: pattern and failure RAMs, match state, line tracking, result.
// ============================================================================
module kmp_dp #(
    parameter int PATTERN_MAX = 32,
    parameter int LINE_MAX    = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [kmp_pkg::ACTION_W-1:0]    i_action,
    input  logic [kmp_pkg::BYTE_W-1:0]      i_data_byte,
    input  kmp_pkg::t_cmd                   i_cmd,
    output kmp_pkg::t_status                o_status,
    output logic                            o_match_here,
    output logic [kmp_pkg::START_W-1:0]     o_match_start,
    output logic                            o_line_found,
    output logic                            o_pattern_overflow
);
    import kmp_pkg::*;

    localparam int IW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PLW = $clog2(PATTERN_MAX + 1);
    localparam int LPW = $clog2(LINE_MAX);
    localparam int DW  = (LPW > PLW) ? LPW : PLW;
    localparam int MW  = (DW > START_W) ? DW : START_W;
    localparam logic [PLW-1:0] PLEN_FULL = PLW'(PATTERN_MAX);
    localparam logic [LPW-1:0] POS_TOP   = LPW'(LINE_MAX - 1);

    logic [ACTION_W-1:0] r_action;
    logic [BYTE_W-1:0]   r_byte;
    logic [PLW-1:0]      r_k;
    logic [PLW-1:0]      n_k;
    logic [PLW-1:0]      r_plen;
    logic [IW-1:0]       r_bpl;
    logic [IW-1:0]       r_last_fail;
    logic [PLW-1:0]      r_matched;
    logic [LPW-1:0]      r_pos;
    logic                r_line_hit;

    logic [BYTE_W-1:0]   pat_q;
    logic [IW-1:0]       fail_q;
    logic [PLW-1:0]      k_m1;
    logic [IW-1:0]       fail_raddr;
    logic                full;
    logic                wr_en;
    logic [IW-1:0]       new_fail;
    logic [PLW-1:0]      plen_m1;
    logic [MW-1:0]       pos_x;
    logic [MW-1:0]       pm1_x;
    logic [MW-1:0]       start_x;

    assign full     = (r_plen >= PLEN_FULL);
    assign wr_en    = i_cmd.finish && (r_action == ACT_APPEND) && !full;
    assign new_fail = (r_plen == '0) ? '0 : r_k[IW-1:0];
    assign plen_m1  = r_plen - PLW'(1);
    assign pos_x    = MW'(r_pos);
    assign pm1_x    = MW'(plen_m1);
    assign start_x  = (pos_x >= pm1_x) ? (pos_x - pm1_x) : '0;

    always_comb begin
        o_status.walk    = (r_plen != '0)
                        && (((i_action == ACT_APPEND) && !full) || (i_action == ACT_TEXT));
        o_status.byte_eq = (pat_q == r_byte);
        o_status.k_zero  = (r_k == '0);
    end

    // RAM read address follows the next k, so read data lines up with r_k
    always_comb begin
        n_k = r_k;
        if (i_cmd.accept) begin
            if (i_action == ACT_TEXT) begin
                n_k = (r_matched >= r_plen) ? '0 : r_matched;
            end else begin
                n_k = PLW'(r_bpl);
            end
        end else if (i_cmd.step) begin
            n_k = PLW'(fail_q);
        end else if (i_cmd.extend) begin
            n_k = o_status.byte_eq ? (r_k + PLW'(1)) : r_k;
        end
    end

    assign k_m1       = n_k - PLW'(1);
    assign fail_raddr = k_m1[IW-1:0];

    kmp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PATTERN_MAX)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_plen[IW-1:0]),
        .i_wdata (r_byte),
        .i_raddr (n_k[IW-1:0]),
        .o_rdata (pat_q)
    );

    kmp_ram #(
        .WIDTH (IW),
        .DEPTH (PATTERN_MAX)
    ) u_fail_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_plen[IW-1:0]),
        .i_wdata (new_fail),
        .i_raddr (fail_raddr),
        .o_rdata (fail_q)
    );

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        if (i_cmd.accept) begin
            r_action <= i_action;
            r_byte   <= i_data_byte;
        end
        if (i_cmd.finish) begin
            o_match_here       <= 1'b0;
            o_match_start      <= '0;
            o_line_found       <= 1'b0;
            o_pattern_overflow <= 1'b0;
            unique case (r_action)
                ACT_CLEAR: ;
                ACT_APPEND: o_pattern_overflow <= full;
                ACT_TEXT: begin
                    if (r_plen != '0 && r_k == r_plen) begin
                        o_match_here  <= 1'b1;
                        o_match_start <= start_x[START_W-1:0];
                    end
                end
                ACT_EOL: o_line_found <= r_line_hit;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen      <= '0;
            r_bpl       <= '0;
            r_last_fail <= '0;
            r_matched   <= '0;
            r_pos       <= '0;
            r_line_hit  <= 1'b0;
        end else if (i_cmd.finish) begin
            unique case (r_action)
                ACT_CLEAR: begin
                    r_plen    <= '0;
                    r_bpl     <= '0;
                    r_matched <= '0;
                end
                ACT_APPEND: begin
                    if (!full) begin
                        r_bpl       <= new_fail;
                        r_last_fail <= new_fail;
                        r_plen      <= r_plen + PLW'(1);
                    end
                end
                ACT_TEXT: begin
                    if (r_plen != '0) begin
                        if (r_k == r_plen) begin
                            r_line_hit <= 1'b1;
                            r_matched  <= PLW'(r_last_fail);
                        end else begin
                            r_matched <= r_k;
                        end
                    end
                    if (r_pos < POS_TOP) begin
                        r_pos <= r_pos + LPW'(1);
                    end
                end
                ACT_EOL: begin
                    r_matched  <= '0;
                    r_pos      <= '0;
                    r_line_hit <= 1'b0;
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_matched_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_matched < r_plen) || (r_matched == '0))
        else $error("matched length reached pattern length");

    a_bpl_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (PLW'(r_bpl) < r_plen) || (r_bpl == '0))
        else $error("build prefix not below pattern length");

    a_walk_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.extend |=> (r_k <= r_plen))
        else $error("walk result exceeds pattern length");
`endif

endmodule
